// File: hw/rtl/wcr_pkg.sv
// wcr_pkg: shared constants, status codes and types for the write-combine range table
// no dependencies; imported by every module of the block

package wcr_pkg;

  // table geometry and page size
  localparam int          WCR_MAX_ENTRIES = 8;
  localparam int          PAGE_BYTES      = 4096;
  localparam logic [11:0] PAGE_MASK       = 12'hfff;
  localparam logic [63:0] MASK_VALID      = 64'h800;

  // configuration register indexes
  localparam logic [1:0] CFG_ADDR_BITS    = 2'd0;
  localparam logic [1:0] CFG_ENTRY_COUNT  = 2'd1;
  localparam logic [1:0] CFG_WC_SUPPORTED = 2'd2;

  // configuration reset values
  localparam logic [5:0] ADDR_BITS_RST    = 6'd36;
  localparam logic [3:0] ENTRY_COUNT_RST  = 4'd8;
  localparam logic       WC_SUPPORTED_RST = 1'b1;

  // address width clamp
  localparam logic [5:0] ADDR_BITS_MIN = 6'd32;
  localparam logic [5:0] ADDR_BITS_MAX = 6'd52;

  // result status codes
  localparam logic [2:0] ST_WRITTEN     = 3'd0;
  localparam logic [2:0] ST_COVERED     = 3'd1;
  localparam logic [2:0] ST_NOFREE      = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_BADSIZE     = 3'd4;
  localparam logic [2:0] ST_MISALIGNED  = 3'd5;
  localparam logic [2:0] ST_LOADED      = 3'd6;

  // one result word
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [63:0] new_base;
    logic [63:0] new_mask;
  } wcr_res_t;

  // table write request (index travels beside it)
  typedef struct packed {
    logic        en;
    logic [63:0] base;
    logic [63:0] mask;
  } wcr_wr_t;

endpackage

// File: hw/rtl/write_combine_range_table.sv
// write_combine_range_table: sequencer over wcr_table and wcr_cover_unit, uses wcr_pkg
// steps after accept: a load word or an unsupported request goes straight to emit; other
// requests round, check the size (bad size exits), check alignment (misaligned exits), then
// scan one entry per cycle through the cover unit (covered exits early) and then emit
// throughput: one word at a time; the input stalls until emit hands the result over
// reset: synchronous active low; table all invalid, address width 36, eight entries, wc on

module write_combine_range_table import wcr_pkg::*; #(
  parameter int MAX_ENTRIES = WCR_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [51:0] in_address,
  input  logic [52:0] in_size_bytes,
  input  logic [2:0]  in_entry_index,
  input  logic [63:0] in_base_word,
  input  logic [63:0] in_mask_word,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_slot,
  output logic [63:0] out_new_base,
  output logic [63:0] out_new_mask,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ALIGN = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [52:0] addr_r, addr_nxt;
  logic [53:0] size_r, size_nxt;
  logic [53:0] size_m1_r, size_m1_nxt;
  logic [53:0] end_r, end_nxt;
  logic [63:0] amask_r, amask_nxt;
  cnt_t        cnt_r, cnt_nxt;
  logic        have_free_r, have_free_nxt;
  idx_t        free_slot_r, free_slot_nxt;
  wcr_res_t    res_r, res_nxt;
  wcr_res_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  addr_bits_r;
  logic [3:0]  entry_count_r;
  logic        wc_supported_r;

  wcr_wr_t     tbl_wr;
  idx_t        tbl_wr_idx;
  logic [63:0] rd_base, rd_mask;
  logic        covers;
  logic        unsupported;
  logic        scan_more;
  logic [5:0]  bits_c;
  logic [63:0] amask_c;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_bits_r    <= ADDR_BITS_RST;
      entry_count_r  <= ENTRY_COUNT_RST;
      wc_supported_r <= WC_SUPPORTED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADDR_BITS:    addr_bits_r    <= cfg_wdata;
        CFG_ENTRY_COUNT:  entry_count_r  <= cfg_wdata[3:0];
        CFG_WC_SUPPORTED: wc_supported_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // entry table and shared cover test
  wcr_table #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .wr_idx  (tbl_wr_idx),
    .rd_idx  (idx_t'(cnt_r)),
    .rd_base (rd_base),
    .rd_mask (rd_mask)
  );

  wcr_cover_unit u_cover (
    .lo       (addr_r),
    .end_incl (end_r),
    .amask    (amask_r),
    .base     (rd_base),
    .mask     (rd_mask),
    .covers   (covers)
  );

  // address mask from clamped width
  always_comb begin
    if (addr_bits_r < ADDR_BITS_MIN) begin
      bits_c = ADDR_BITS_MIN;
    end else if (addr_bits_r > ADDR_BITS_MAX) begin
      bits_c = ADDR_BITS_MAX;
    end else begin
      bits_c = addr_bits_r;
    end
    amask_c = ~({64{1'b1}} << bits_c);
  end

  assign unsupported = !wc_supported_r || (entry_count_r == 4'd0) ||
                       (32'(entry_count_r) > MAX_ENTRIES);
  assign scan_more   = (5'(cnt_r) < {1'b0, entry_count_r});
  assign in_stall    = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    size_nxt      = size_r;
    size_m1_nxt   = size_m1_r;
    end_nxt       = end_r;
    amask_nxt     = amask_r;
    cnt_nxt       = cnt_r;
    have_free_nxt = have_free_r;
    free_slot_nxt = free_slot_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    tbl_wr        = '0;
    tbl_wr_idx    = free_slot_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            // direct load, ignored beyond the table
            if (32'(in_entry_index) < MAX_ENTRIES) begin
              tbl_wr.en   = 1'b1;
              tbl_wr.base = in_base_word;
              tbl_wr.mask = in_mask_word;
              tbl_wr_idx  = idx_t'(in_entry_index);
              res_nxt     = '{ST_LOADED, in_entry_index, in_base_word, in_mask_word};
            end else begin
              res_nxt = '{ST_LOADED, 3'd0, 64'd0, 64'd0};
            end
            state_nxt = S_EMIT;
          end else if (unsupported) begin
            res_nxt   = '{ST_UNSUPPORTED, 3'd0, 64'd0, 64'd0};
            state_nxt = S_EMIT;
          end else begin
            addr_nxt  = {1'b0, in_address};
            size_nxt  = {1'b0, in_size_bytes};
            state_nxt = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        // round address and size up to a page
        addr_nxt  = (addr_r + {41'd0, PAGE_MASK}) & ~{41'd0, PAGE_MASK};
        size_nxt  = (size_r + {42'd0, PAGE_MASK}) & ~{42'd0, PAGE_MASK};
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // size must be a nonzero power of two
        if (!$onehot(size_r)) begin
          res_nxt   = '{ST_BADSIZE, 3'd0, 64'd0, 64'd0};
          state_nxt = S_EMIT;
        end else begin
          size_m1_nxt = size_r - 54'd1;
          state_nxt   = S_ALIGN;
        end
      end
      S_ALIGN: begin
        // alignment only matters above one page
        if ((|size_r[53:13]) && (|({1'b0, addr_r} & size_m1_r))) begin
          res_nxt   = '{ST_MISALIGNED, 3'd0, 64'd0, 64'd0};
          state_nxt = S_EMIT;
        end else begin
          end_nxt       = {1'b0, addr_r} + size_m1_r;
          amask_nxt     = amask_c;
          cnt_nxt       = '0;
          have_free_nxt = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_more) begin
          // one entry per cycle
          if (rd_mask[11]) begin
            if (covers) begin
              res_nxt   = '{ST_COVERED, 3'd0, 64'd0, 64'd0};
              state_nxt = S_EMIT;
            end
          end else if (!have_free_r) begin
            have_free_nxt = 1'b1;
            free_slot_nxt = idx_t'(cnt_r);
          end
          cnt_nxt = cnt_r + cnt_t'(1);
        end else if (!have_free_r) begin
          res_nxt   = '{ST_NOFREE, 3'd0, 64'd0, 64'd0};
          state_nxt = S_EMIT;
        end else begin
          // claim the first free entry
          tbl_wr.en   = 1'b1;
          tbl_wr.base = ({11'd0, addr_r} & amask_r) | 64'd1;
          tbl_wr.mask = (~{10'd0, size_m1_r} & amask_r) | MASK_VALID;
          res_nxt     = '{ST_WRITTEN, 3'(free_slot_r), tbl_wr.base, tbl_wr.mask};
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        // hand over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      have_free_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      have_free_r <= have_free_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    size_r      <= size_nxt;
    size_m1_r   <= size_m1_nxt;
    end_r       <= end_nxt;
    amask_r     <= amask_nxt;
    free_slot_r <= free_slot_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_slot     = out_r.slot;
  assign out_new_base = out_r.new_base;
  assign out_new_mask = out_r.new_mask;

  // a new result only comes out of the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit step");

  // scan never runs past the entry count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (5'(cnt_r) <= {1'b0, entry_count_r}))
    else $error("scan index beyond entry count");

  // a written entry is always valid and typed write-combining
  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_WRITTEN) |-> (out_r.new_mask[11] && out_r.new_base[0]))
    else $error("written entry not valid");

  // results without a table write carry zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_WRITTEN && out_r.status != ST_LOADED) |->
      (out_r.slot == 3'd0 && out_r.new_base == 64'd0 && out_r.new_mask == 64'd0))
    else $error("nonzero payload on a result without a write");

endmodule

// File: hw/rtl/wcr_table.sv
// wcr_table: range entry register file, one write port, one read port, cleared by reset
// depends on wcr_pkg for the write request type

module wcr_table import wcr_pkg::*; #(
  parameter int DEPTH = WCR_MAX_ENTRIES,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wcr_wr_t          wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [63:0]      rd_base,
  output logic [63:0]      rd_mask
);

  logic [63:0] base_r [DEPTH];
  logic [63:0] mask_r [DEPTH];

  // entry storage, all invalid after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        base_r[i] <= '0;
        mask_r[i] <= '0;
      end
    end else if (wr.en) begin
      base_r[wr_idx] <= wr.base;
      mask_r[wr_idx] <= wr.mask;
    end
  end

  // entry under scan
  assign rd_base = base_r[rd_idx];
  assign rd_mask = mask_r[rd_idx];

endmodule

// File: hw/rtl/wcr_cover_unit.sv
// wcr_cover_unit: shared per-entry test, does one range entry contain the request range
// depends on wcr_pkg for the page mask

module wcr_cover_unit import wcr_pkg::*; (
  input  logic [52:0] lo,
  input  logic [53:0] end_incl,
  input  logic [63:0] amask,
  input  logic [63:0] base,
  input  logic [63:0] mask,
  output logic        covers
);

  logic [63:0] b_al;
  logic [63:0] span;
  logic [64:0] last;

  // entry start and inclusive end, carry means it reaches the top
  always_comb begin
    b_al = base & ~{52'd0, PAGE_MASK};
    span = amask & ~(mask & ~{52'd0, PAGE_MASK});
    last = {1'b0, b_al} + {1'b0, span};
  end

  // type bit 0, lower bound, then upper bound
  always_comb begin
    if (!base[0]) begin
      covers = 1'b0;
    end else if ({11'd0, lo} < b_al) begin
      covers = 1'b0;
    end else if (last[64]) begin
      covers = 1'b1;
    end else begin
      covers = ({10'd0, end_incl} <= last[63:0]);
    end
  end

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for write_combine_range_table, directed table then random words
// depends on wcr_pkg and write_combine_range_table; holds its own shadow of the range table
`timescale 1ns / 100ps

module tb_top;
  import wcr_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 500;
  localparam int SETTLE_CYCLES = 30;
  localparam int WATCH_LIMIT   = 4000;
  localparam int RAND_PER_SET  = 193;

  // one input word
  typedef struct packed {
    logic        kind;
    logic [51:0] address;
    logic [52:0] size_bytes;
    logic [2:0]  entry_index;
    logic [63:0] base_word;
    logic [63:0] mask_word;
  } wc_word_t;

  // one row of the directed table
  typedef struct packed {
    wc_word_t w;
    logic     typed;
    wcr_res_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [51:0] in_address;
  logic [52:0] in_size_bytes;
  logic [2:0]  in_entry_index;
  logic [63:0] in_base_word;
  logic [63:0] in_mask_word;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [2:0]  out_slot;
  logic [63:0] out_new_base;
  logic [63:0] out_new_mask;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_wdata;

  // shadow of the range table and its registers
  logic [63:0] shadow_base [WCR_MAX_ENTRIES];
  logic [63:0] shadow_mask [WCR_MAX_ENTRIES];
  logic [5:0]  shadow_addr_bits;
  logic [3:0]  shadow_entry_count;
  logic        shadow_wc_on;

  // last range granted, used to aim requests at covered space
  logic        have_grant;
  logic [63:0] grant_addr;
  logic [63:0] grant_size;

  wcr_res_t    pending_results [$];
  dir_row_t    dir_rows [$];
  int          mismatches;
  int          results_seen;
  bit          send_quiet;
  bit          recv_quiet;
  bit          hold_done;

  write_combine_range_table uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .in_size_bytes  (in_size_bytes),
    .in_entry_index (in_entry_index),
    .in_base_word   (in_base_word),
    .in_mask_word   (in_mask_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_new_base   (out_new_base),
    .out_new_mask   (out_new_mask),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // physical address mask with the width clamped to 32..52
  function automatic logic [63:0] addr_mask();
    int bits;
    bits = shadow_addr_bits;
    if (bits < ADDR_BITS_MIN) bits = ADDR_BITS_MIN;
    if (bits > ADDR_BITS_MAX) bits = ADDR_BITS_MAX;
    return (64'd1 << bits) - 64'd1;
  endfunction

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // next result of the table for one word; updates the shadow table
  function automatic wcr_res_t predict_result(wc_word_t w);
    wcr_res_t    r;
    logic [63:0] lo, sz, am, b_al, span, last;
    bit          found_free;
    int          free_k;
    r = '0;
    found_free = 1'b0;
    free_k = 0;
    if (w.kind) begin
      shadow_base[w.entry_index] = w.base_word;
      shadow_mask[w.entry_index] = w.mask_word;
      r.status   = ST_LOADED;
      r.slot     = w.entry_index;
      r.new_base = w.base_word;
      r.new_mask = w.mask_word;
      return r;
    end
    if (!shadow_wc_on || shadow_entry_count == 0 || shadow_entry_count > WCR_MAX_ENTRIES) begin
      r.status = ST_UNSUPPORTED;
      return r;
    end
    // round both up to a page
    lo = ({12'd0, w.address} + 64'hfff) & ~64'hfff;
    sz = ({11'd0, w.size_bytes} + 64'hfff) & ~64'hfff;
    if (sz == 0 || (sz & (sz - 64'd1)) != 0) begin
      r.status = ST_BADSIZE;
      return r;
    end
    if (sz > PAGE_BYTES && (lo & (sz - 64'd1)) != 0) begin
      r.status = ST_MISALIGNED;
      return r;
    end
    am = addr_mask();
    // scan entries in use: covered by a valid wc-typed entry, else remember first free
    for (int k = 0; k < shadow_entry_count; k++) begin
      if (shadow_mask[k][11]) begin
        b_al = shadow_base[k] & ~64'hfff;
        if (shadow_base[k][0] && lo >= b_al) begin
          span = am & ~(shadow_mask[k] & ~64'hfff);
          last = b_al + span;
          if (last < b_al || lo + sz - 64'd1 <= last) begin
            r.status = ST_COVERED;
            return r;
          end
        end
      end else if (!found_free) begin
        found_free = 1'b1;
        free_k = k;
      end
    end
    if (!found_free) begin
      r.status = ST_NOFREE;
      return r;
    end
    r.status   = ST_WRITTEN;
    r.slot     = 3'(free_k);
    r.new_base = (lo & am) | 64'd1;
    r.new_mask = (~(sz - 64'd1) & am) | MASK_VALID;
    shadow_base[free_k] = r.new_base;
    shadow_mask[free_k] = r.new_mask;
    have_grant = 1'b1;
    grant_addr = lo;
    grant_size = sz;
    return r;
  endfunction

  // directed rows: requests and loads
  task automatic add_request(logic [51:0] a, logic [52:0] s, logic typed, wcr_res_t res);
    dir_row_t row;
    row = '0;
    row.w.address    = a;
    row.w.size_bytes = s;
    row.typed        = typed;
    row.res          = res;
    dir_rows.push_back(row);
  endtask

  task automatic add_load(logic [2:0] idx, logic [63:0] b, logic [63:0] m);
    dir_row_t row;
    row = '0;
    row.w.kind        = 1'b1;
    row.w.entry_index = idx;
    row.w.base_word   = b;
    row.w.mask_word   = m;
    row.typed         = 1'b1;
    row.res           = '{ST_LOADED, idx, b, m};
    dir_rows.push_back(row);
  endtask

  // offer one word after a random gap and record its expected result on accept
  task automatic offer_word(wc_word_t w, logic typed, wcr_res_t typed_res);
    wcr_res_t p;
    repeat (pick_gap(send_quiet)) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_kind        = w.kind;
    in_address     = w.address;
    in_size_bytes  = w.size_bytes;
    in_entry_index = w.entry_index;
    in_base_word   = w.base_word;
    in_mask_word   = w.mask_word;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_result(w);
    pending_results.push_back(typed ? typed_res : p);
  endtask

  // random word: loads, probes into granted space, well-formed requests, noise
  task automatic make_word(output wc_word_t w);
    int          pick, v, k;
    logic [63:0] am, sz, a, sub, off;
    w.kind        = 1'b0;
    w.address     = 52'(rnd64());
    w.size_bytes  = 53'(rnd64());
    w.entry_index = 3'($urandom);
    w.base_word   = rnd64();
    w.mask_word   = rnd64();
    am   = addr_mask();
    pick = $urandom_range(0, 99);
    v    = $urandom_range(0, 9);
    if (pick < 30) begin
      w.kind = 1'b1;
      if (v < 5) begin
        w.mask_word[11] = 1'b0;
      end else if (v < 7) begin
        w.mask_word[11] = 1'b1;
      end else begin
        k  = $urandom_range(12, 40);
        sz = 64'd1 << k;
        w.base_word = (rnd64() & am & ~(sz - 64'd1)) | 64'($urandom_range(0, 1));
        w.mask_word = (~(sz - 64'd1) & am) | MASK_VALID;
      end
    end else if (pick < 50 && have_grant) begin
      sub = grant_size;
      while (sub > PAGE_BYTES && $urandom_range(0, 1)) sub = sub >> 1;
      off = rnd64() & ((grant_size / sub) - 64'd1);
      a   = grant_addr + off * sub;
      w.address    = a[51:0];
      w.size_bytes = sub[52:0];
    end else if (pick < 88) begin
      k  = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 52) : $urandom_range(12, 24);
      sz = 64'd1 << k;
      a  = rnd64() & am & ~(sz - 64'd1);
      if (v == 0 && k == 12) sz = sz - 64'($urandom_range(0, 4095));
      if (v == 1) a = a + 64'($urandom_range(1, 4095));
      if (v == 2) a = a + (64'd1 << $urandom_range(12, k));
      w.address    = a[51:0];
      w.size_bytes = sz[52:0];
    end else begin
      if (v < 3) w.size_bytes = 53'($urandom_range(0, 20000));
      else if (v == 3) w.size_bytes = '0;
    end
  endtask

  task automatic run_random(int n);
    wc_word_t w;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) send_quiet = ($urandom_range(0, 4) == 0);
      make_word(w);
      offer_word(w, 1'b0, '0);
    end
  endtask

  // idle the input and wait until every result is back and the block has settled
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ADDR_BITS:    shadow_addr_bits   = val;
      CFG_ENTRY_COUNT:  shadow_entry_count = val[3:0];
      CFG_WC_SUPPORTED: shadow_wc_on       = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [5:0] bits, logic [5:0] count, logic [5:0] wc);
    drain();
    write_reg(CFG_ADDR_BITS, bits);
    write_reg(CFG_ENTRY_COUNT, count);
    write_reg(CFG_WC_SUPPORTED, wc);
  endtask

  task automatic report(string field, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
  endtask

  // result side: compare each accepted word with the oldest expectation
  initial begin : result_check
    wcr_res_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, status %0d slot %0d base %0h mask %0h",
                   $time, out_status, out_slot, out_new_base, out_new_mask);
        end else begin
          e = pending_results.pop_front();
          if (out_status !== e.status) report("status", e.status, out_status);
          if (out_slot !== e.slot) report("slot", e.slot, out_slot);
          if (out_new_base !== e.new_base) report("new_base", e.new_base, out_new_base);
          if (out_new_mask !== e.new_mask) report("new_mask", e.new_mask, out_new_mask);
        end
      end
    end
  end

  // receiver stalls, one long hold-off so the block backs up into its input
  initial begin : result_stall
    int loops;
    loops = 0;
    out_stall = 1'b0;
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (loops % 100 == 0) recv_quiet = ($urandom_range(0, 4) == 0);
      loops++;
      repeat (pick_gap(recv_quiet)) begin
        out_stall = 1'b1;
        @(negedge clk);
      end
      out_stall = 1'b0;
      @(negedge clk);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCH_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("write_combine_range_table verification failed");
    $finish;
  end

  initial begin : stimulus
    send_quiet   = 1'b0;
    have_grant   = 1'b0;
    grant_addr   = '0;
    grant_size   = '0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind        = 1'b0;
    in_address     = '0;
    in_size_bytes  = '0;
    in_entry_index = '0;
    in_base_word   = '0;
    in_mask_word   = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ADDR_BITS;
    cfg_wdata      = '0;
    for (int k = 0; k < WCR_MAX_ENTRIES; k++) begin
      shadow_base[k] = '0;
      shadow_mask[k] = '0;
    end
    shadow_addr_bits   = ADDR_BITS_RST;
    shadow_entry_count = ENTRY_COUNT_RST;
    shadow_wc_on       = WC_SUPPORTED_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero size, first grant, repeat is covered, odd multiple, misaligned
    add_request(52'd0, 53'd0, 1'b1, '{ST_BADSIZE, 3'd0, 64'd0, 64'd0});
    add_request(52'd0, 53'd4096, 1'b1, '{ST_WRITTEN, 3'd0, 64'h1, 64'hf_ffff_f800});
    add_request(52'd0, 53'd4096, 1'b1, '{ST_COVERED, 3'd0, 64'd0, 64'd0});
    add_request(52'd0, 53'd12288, 1'b1, '{ST_BADSIZE, 3'd0, 64'd0, 64'd0});
    add_request(52'd4096, 53'd8192, 1'b1, '{ST_MISALIGNED, 3'd0, 64'd0, 64'd0});
    // sub-page address and size round up, largest size, size and address that round past the top
    add_request(52'd1, 53'd1, 1'b0, '0);
    add_request(52'd0, 53'h10_0000_0000_0000, 1'b0, '0);
    add_request(52'd0, {53{1'b1}}, 1'b0, '0);
    add_request({52{1'b1}}, 53'd4096, 1'b0, '0);
    // loads: all ones, clears, an entry without the wc type bit, an entry ending past 2^64
    add_load(3'd7, {64{1'b1}}, {64{1'b1}});
    add_load(3'd0, 64'd0, 64'd0);
    add_load(3'd2, 64'd0, 64'd0);
    add_load(3'd3, 64'd0, 64'd0);
    add_load(3'd5, 64'h10_0000, 64'hf_ffff_f800);
    add_load(3'd6, 64'hffff_ffff_ffff_f001, 64'h800);
    // type bit clear does not cover, then more grants and a last request expected to find no free entry
    add_request(52'h10_0000, 53'd4096, 1'b0, '0);
    add_request(52'h10_0000, 53'd4096, 1'b0, '0);
    add_request(52'h20_0000, 53'd4096, 1'b0, '0);
    add_request(52'h30_0000, 53'd5000, 1'b0, '0);
    add_request(52'h40_0000, 53'd4096, 1'b1, '{ST_NOFREE, 3'd0, 64'd0, 64'd0});
    foreach (dir_rows[i]) offer_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    // random words across register settings, extremes among them
    run_random(RAND_PER_SET);
    set_config(6'd32, 6'd8, 6'd1);
    run_random(RAND_PER_SET);
    set_config(6'd52, 6'd8, 6'd1);
    run_random(RAND_PER_SET);
    set_config(6'd0, 6'd3, 6'd1);
    run_random(RAND_PER_SET);
    set_config(6'd63, 6'd1, 6'd1);
    run_random(RAND_PER_SET);
    set_config(6'd36, 6'd0, 6'd1);
    run_random(RAND_PER_SET);
    set_config(6'd44, 6'd15, 6'd1);
    run_random(RAND_PER_SET);
    set_config(6'd48, 6'd8, 6'd0);
    run_random(RAND_PER_SET);
    set_config(6'd40, 6'd5, 6'd1);
    run_random(RAND_PER_SET);
    set_config(6'd52, 6'd8, 6'd1);
    run_random(RAND_PER_SET);
    drain();

    if (mismatches == 0) begin
      $display("write_combine_range_table verification clean");
    end else begin
      $display("write_combine_range_table verification failed");
    end
    $finish;
  end

endmodule

// File: write_combine_range_table.f
hw/rtl/wcr_pkg.sv
hw/rtl/wcr_table.sv
hw/rtl/wcr_cover_unit.sv
hw/rtl/write_combine_range_table.sv
bench/tb_top.sv
